// ===== src/rrpb_pkg.sv =====
`timescale 1ns / 1ps

package rrpb_pkg;

  // Command codes on the input channel
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Bits held by one cell
  localparam int WORD_W   = 32;
  localparam int BIT_IDX_W = 5;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                 push;     // set bit_sel in the selected cell
    logic                 start;    // drop the scan token into the selected cell
    logic [BIT_IDX_W-1:0] bit_sel;  // push bit, or first bit of the scan
  } rrpb_ctl_t;

  // Status returned by each cell; zero unless the cell reports something
  typedef struct packed {
    logic                 hit;       // token found a pending bit here
    logic [BIT_IDX_W-1:0] hit_bit;   // lowest pending bit in the scan window
    logic                 newly_set; // push set a bit that was clear
  } rrpb_stat_t;

endpackage

// ===== src/rrpb_cell.sv =====
`timescale 1ns / 1ps

module rrpb_cell
  import rrpb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rrpb_ctl_t  ctl,
  input  logic       sel,
  input  logic       token_in,
  output logic       token_out,
  output rrpb_stat_t stat
);

  logic [WORD_W-1:0]    word_r, word_nxt;
  logic                 token_r, token_nxt;
  logic                 first_r, first_nxt;
  logic [WORD_W-1:0]    window;
  logic [WORD_W-1:0]    cand;
  logic [BIT_IDX_W-1:0] low_idx;
  logic                 hit;

  // Restrict the first visit to bits at or above the scan start
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      window[b] = (BIT_IDX_W'(b) >= ctl.bit_sel);
    end
  end

  assign cand = word_r & (first_r ? window : {WORD_W{1'b1}});
  assign hit  = token_r & (|cand);

  // Find the lowest pending bit in the window
  always_comb begin
    low_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        low_idx = BIT_IDX_W'(b);
      end
    end
  end

  // Set on push, clear on hit
  always_comb begin
    word_nxt = word_r;
    if (ctl.push && sel) begin
      word_nxt[ctl.bit_sel] = 1'b1;
    end
    if (hit) begin
      word_nxt[low_idx] = 1'b0;
    end
  end

  // Take the token from the controller or the neighbor, pass it on when empty
  assign token_nxt = (ctl.start && sel) || token_in;
  assign first_nxt = ctl.start && sel;
  assign token_out = token_r && !hit;

  assign stat.hit       = hit;
  assign stat.hit_bit   = hit ? low_idx : '0;
  assign stat.newly_set = ctl.push && sel && !word_r[ctl.bit_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r  <= '0;
      token_r <= 1'b0;
      first_r <= 1'b0;
    end else begin
      word_r  <= word_nxt;
      token_r <= token_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

// ===== src/round_robin_pending_bitmap.sv =====
`timescale 1ns / 1ps

// Round-robin pending bitmap.
// Input channel (in_valid / in_stall): in_command selects push (mark
// in_ident pending) or pop (take the next pending identifier at or after the
// scan pointer, wrapping at NUM_IDS). Every request gives one result on the
// output channel (out_valid / out_stall): popped identifier and flag, an
// empty error for a pop with nothing pending, and whether anything is still
// pending afterwards.
// The bitmap sits in a ring of 32-bit cells; a pop drops a token into the
// cell of the scan pointer and the token walks one cell per cycle until it
// finds a pending bit. A push or an empty pop goes from accept to the result
// state; a pop with something pending goes through the search state first,
// visiting 1 to NUM_WORDS + 1 cells (the start cell may be visited twice).
// The result is held in an output register; the block takes the next request
// as soon as its result is in that register, even while out_stall is high.
// A finished result that finds the output register full waits inside the
// block, and in_stall stays high meanwhile.
// Reset (rst_n low, synchronous) clears all pending bits, the scan pointer
// and the output register; no clearing pass is needed.

module round_robin_pending_bitmap
  import rrpb_pkg::*;
#(
  parameter int NUM_IDS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_ident,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_popped_ident,
  output logic       out_popped_valid,
  output logic       out_empty_error,
  output logic       out_any_pending
);

  localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PTR_W     = WIDX_W + BIT_IDX_W;
  localparam int CNT_W     = $clog2(NUM_IDS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RESP   = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WIDX_W-1:0] cur_word_r, cur_word_nxt;

  logic [7:0] res_id_r, res_id_nxt;
  logic       res_valid_r, res_valid_nxt;
  logic       res_err_r, res_err_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_id_r, out_id_nxt;
  logic       out_pv_r, out_pv_nxt;
  logic       out_err_r, out_err_nxt;
  logic       out_any_r, out_any_nxt;

  logic              accept;
  logic              out_free;
  logic              id_in_range;
  logic [WIDX_W-1:0] in_word;
  logic [WIDX_W-1:0] wsel;
  logic [PTR_W-1:0]  pos;
  logic [PTR_W:0]    pos_inc;

  rrpb_ctl_t               ctl;
  rrpb_stat_t [NUM_WORDS-1:0] stat_v;
  rrpb_stat_t              stat_any;
  logic [NUM_WORDS-1:0]    tok_pass;
  logic [NUM_WORDS-1:0]    sel_v;

  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state_r != ST_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign id_in_range = (32'(in_ident) < NUM_IDS);
  assign in_word     = WIDX_W'(in_ident >> BIT_IDX_W);

  // Drive the cell broadcast: push at accept, scan start from the pointer
  assign wsel        = accept ? ((in_command == CMD_PUSH) ? in_word : ptr_r[PTR_W-1:BIT_IDX_W])
                              : ptr_r[PTR_W-1:BIT_IDX_W];
  assign ctl.push    = accept && (in_command == CMD_PUSH) && id_in_range;
  assign ctl.start   = accept && (in_command == CMD_POP) && (count_r != '0);
  assign ctl.bit_sel = (accept && (in_command == CMD_PUSH)) ? in_ident[BIT_IDX_W-1:0]
                                                            : ptr_r[BIT_IDX_W-1:0];

  // Row of cells, token ring closed from the last cell to the first
  for (genvar i = 0; i < NUM_WORDS; i++) begin : g_cell
    assign sel_v[i] = (wsel == WIDX_W'(i));
    rrpb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .sel       (sel_v[i]),
      .token_in  (tok_pass[(i + NUM_WORDS - 1) % NUM_WORDS]),
      .token_out (tok_pass[i]),
      .stat      (stat_v[i])
    );
  end

  // Merge cell status; at most one cell reports at a time
  always_comb begin
    stat_any = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      stat_any = rrpb_stat_t'(stat_any | stat_v[i]);
    end
  end

  assign pos     = {cur_word_r, stat_any.hit_bit};
  assign pos_inc = {1'b0, pos} + (PTR_W + 1)'(1);

  // Sequence one request at a time
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    cur_word_nxt  = cur_word_r;
    res_id_nxt    = res_id_r;
    res_valid_nxt = res_valid_r;
    res_err_nxt   = res_err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_id_nxt    = '0;
          res_valid_nxt = 1'b0;
          res_err_nxt   = 1'b0;
          if (in_command == CMD_PUSH) begin
            count_nxt = count_r + CNT_W'(stat_any.newly_set);
            state_nxt = ST_RESP;
          end else if (count_r == '0) begin
            res_err_nxt = 1'b1;
            state_nxt   = ST_RESP;
          end else begin
            cur_word_nxt = ptr_r[PTR_W-1:BIT_IDX_W];
            state_nxt    = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (stat_any.hit) begin
          res_id_nxt    = 8'(pos);
          res_valid_nxt = 1'b1;
          count_nxt     = count_r - CNT_W'(1);
          ptr_nxt       = (pos_inc == (PTR_W + 1)'(NUM_IDS)) ? '0 : pos_inc[PTR_W-1:0];
          state_nxt     = ST_RESP;
        end else if (cur_word_r == WIDX_W'(NUM_WORDS - 1)) begin
          cur_word_nxt = '0;
        end else begin
          cur_word_nxt = cur_word_r + WIDX_W'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Load the output register, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_pv_nxt    = out_pv_r;
    out_err_nxt   = out_err_r;
    out_any_nxt   = out_any_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_RESP) && out_free) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = res_id_r;
      out_pv_nxt    = res_valid_r;
      out_err_nxt   = res_err_r;
      out_any_nxt   = (count_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_word_r  <= cur_word_nxt;
    res_id_r    <= res_id_nxt;
    res_valid_r <= res_valid_nxt;
    res_err_r   <= res_err_nxt;
    out_id_r    <= out_id_nxt;
    out_pv_r    <= out_pv_nxt;
    out_err_r   <= out_err_nxt;
    out_any_r   <= out_any_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_ident = out_id_r;
  assign out_popped_valid = out_pv_r;
  assign out_empty_error  = out_err_r;
  assign out_any_pending  = out_any_r;

  // At most one scan token alive in the ring
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_pass))
    else $error("more than one scan token in the cell ring");

  // Cells report a hit only while a scan runs
  a_hit_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    stat_any.hit |-> (state_r == ST_SEARCH))
    else $error("cell hit outside a scan");

  // A scan only runs with something pending
  a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (count_r != '0))
    else $error("scan running with nothing pending");

  // A result never carries both an identifier and an empty error
  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_pv_r && out_err_r))
    else $error("result flags popped and empty together");

endmodule
